// File: sv/pamd_pkg.sv
package pamd_pkg;

  // Request kinds carried in tuser.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_DEMAP = 1'b1;

  // Configuration register indexes.
  localparam logic [0:0] REG_BITS  = 1'b0;
  localparam logic [0:0] REG_NOISE = 1'b1;

  // Metric width in Q.9.
  localparam int MetricW = 40;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MRD,
    ST_MCALC,
    ST_MMUL,
    ST_XRD,
    ST_XCMP,
    ST_OUT
  } state_t;

endpackage

// File: sv/pamd_ram.sv
module pamd_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/prior_aware_maxlog_demapper.sv
// Load word: accepted in idle, where the block stays, ready for the next word.
// Demap word with P = 2^B points: P passes through the read, calculate and
// multiply states build the metrics, then for each of the B bits a sweep over
// the P metrics finds both maxima and the result is presented and held until
// the receiver takes it; after the last result the block returns to idle.
// The metric pass is point-serial and the metric memory has one read port.
// Reset (rst, synchronous) returns to idle with B = 6 and noise scale 1.0;
// the point and metric memories keep their contents.
module prior_aware_maxlog_demapper #(
  parameter int MAX_BITS    = 8,
  parameter int TABLE_DEPTH = 256,
  parameter int LLR_WIDTH   = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // tdata: point_index[7:0], coord_i[23:8], coord_q[39:24], prior_0..prior_7 from 40 up
  input  logic [8+32+16*MAX_BITS-1:0] s_axis_tdata,
  // tuser: req_type
  input  logic                      s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // tdata: ext_llr[LLR_WIDTH-1:0], bit_position[LLR_WIDTH+2:LLR_WIDTH], zero fill
  output logic [((LLR_WIDTH+3+7)/8)*8-1:0] m_axis_tdata,
  output logic                      m_axis_tlast,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [0:0]                cfg_index,
  input  logic [15:0]               cfg_data
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int MW  = pamd_pkg::MetricW;
  localparam int BW  = $clog2(MAX_BITS);
  localparam int OW  = ((LLR_WIDTH + 3 + 7) / 8) * 8;
  localparam int TW  = $clog2(MAX_BITS + 1);

  pamd_pkg::state_t state, state_next;

  logic [3:0]  bits_reg;
  logic [15:0] noise;
  logic [TW-1:0] nb;              // effective bit count
  logic [AW:0]   idx;             // point counter, can hold the point count
  logic [BW-1:0] kbit;
  logic signed [15:0] yi, yq;
  logic signed [15:0] pri [MAX_BITS];
  logic signed [33:0] d2;
  logic signed [MW-1:0] psum;     // prior sum of the current point
  logic signed [MW-1:0] max0, max1;
  logic have0, have1;
  logic [LLR_WIDTH-1:0] llr_out;
  logic [BW-1:0] pos_out;
  logic last_out;

  // Effective bit count after clamping to 2..MAX_BITS and to the table depth.
  always_comb begin
    logic [TW:0] b;
    b = {1'b0, bits_reg} < (TW+1)'(2) ? (TW+1)'(2) : (TW+1)'(bits_reg);
    if (b > (TW+1)'(MAX_BITS)) b = (TW+1)'(MAX_BITS);
    for (int i = 0; i < 8; i++) begin
      if (b > (TW+1)'(2) && ((32'd1 << b) > 32'(TABLE_DEPTH))) b = b - (TW+1)'(1);
    end
    nb = b[TW-1:0];
  end

  wire [AW:0] npts = (AW+1)'(1) << nb;
  wire in_fire  = s_axis_tvalid && s_axis_tready;
  wire cfg_fire = cfg_valid && cfg_ready;
  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state == pamd_pkg::ST_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bits_reg <= 4'd6;
      noise    <= 16'd256;
    end else if (cfg_fire) begin
      case (cfg_index)
        pamd_pkg::REG_BITS:  bits_reg <= cfg_data[3:0];
        pamd_pkg::REG_NOISE: noise    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Point table and metric memory; I sits in the high half of a point.
  logic [31:0] pt_rd;
  logic [MW-1:0] met_rd, met_wd;
  logic met_we;
  wire [AW-1:0] ridx = idx[AW-1:0];
  logic [AW-1:0] met_wa;
  wire ld_ok = in_fire && (s_axis_tuser == pamd_pkg::REQ_LOAD) &&
               ({1'b0, s_axis_tdata[7:0]} < 9'(TABLE_DEPTH));

  pamd_ram #(.Width(32), .Depth(TABLE_DEPTH)) u_pts (
    .clk(clk), .we(ld_ok), .waddr(s_axis_tdata[AW-1:0]),
    .wdata({s_axis_tdata[23:8], s_axis_tdata[39:24]}), .raddr(ridx), .rdata(pt_rd));

  pamd_ram #(.Width(MW), .Depth(TABLE_DEPTH)) u_met (
    .clk(clk), .we(met_we), .waddr(met_wa), .wdata(met_wd),
    .raddr(ridx), .rdata(met_rd));

  // Multiplier: squared distance times noise scale.
  wire signed [16:0] di = 17'(yi) - 17'($signed(pt_rd[31:16]));
  wire signed [16:0] dq = 17'(yq) - 17'($signed(pt_rd[15:0]));
  wire [49:0] prod = 50'(d2) * 50'(noise);
  wire [49:0] prod_r = prod + (50'd1 << 24);

  // Bit j of point p in label order (bit 0 is the MSB).
  function automatic logic lbit(input logic [AW:0] p, input logic [TW-1:0] n,
                                input int j);
    logic [TW:0] sh;
    sh = (TW+1)'(n) - (TW+1)'(1) - (TW+1)'(j);
    return p[sh[$clog2(AW+1)-1:0]];
  endfunction

  wire [AW:0] pidx = idx - (AW+1)'(1); // point whose data came from memory

  always_comb begin
    state_next = state;
    case (state)
      pamd_pkg::ST_IDLE:
        if (in_fire && s_axis_tuser == pamd_pkg::REQ_DEMAP) state_next = pamd_pkg::ST_MRD;
      pamd_pkg::ST_MRD:   state_next = pamd_pkg::ST_MCALC;
      pamd_pkg::ST_MCALC: state_next = pamd_pkg::ST_MMUL;
      pamd_pkg::ST_MMUL:
        state_next = (idx == npts) ? pamd_pkg::ST_XRD : pamd_pkg::ST_MRD;
      pamd_pkg::ST_XRD:   state_next = pamd_pkg::ST_XCMP;
      pamd_pkg::ST_XCMP:
        if (idx == npts) state_next = pamd_pkg::ST_OUT;
      pamd_pkg::ST_OUT:
        if (m_axis_tready)
          state_next = (32'(kbit) == 32'(nb) - 1) ? pamd_pkg::ST_IDLE : pamd_pkg::ST_XRD;
      default: state_next = pamd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= pamd_pkg::ST_IDLE;
    else state <= state_next;
  end

  // Metric write, prior sum minus the rounded product.
  always_comb begin
    met_we = (state == pamd_pkg::ST_MMUL);
    met_wa = pidx[AW-1:0];
    met_wd = psum - MW'($signed({1'b0, prod_r[49:25]}));
  end

  wire signed [MW-1:0] prk = MW'(pri[kbit]);
  wire mb = lbit(pidx, nb, 32'(kbit));
  wire signed [MW-1:0] mval = $signed(met_rd) + (mb ? prk : -prk);
  wire signed [MW:0] diff = (MW+1)'(max0) - (MW+1)'(max1) + (MW+1)'(1);
  wire signed [MW:0] half = diff >>> 1;
  localparam logic signed [MW:0] Hi = (MW+1)'((64'sd1 <<< (LLR_WIDTH-1)) - 1);
  localparam logic signed [MW:0] Lo = -Hi - 1;

  // Datapath registers under the sequencer.
  always_ff @(posedge clk) begin
    case (state)
      pamd_pkg::ST_IDLE: begin
        idx  <= '0;
        kbit <= '0;
        if (in_fire) begin
          yi <= $signed(s_axis_tdata[23:8]);
          yq <= $signed(s_axis_tdata[39:24]);
          for (int j = 0; j < MAX_BITS; j++) pri[j] <= $signed(s_axis_tdata[40+16*j +: 16]);
        end
      end
      pamd_pkg::ST_MRD: idx <= idx + (AW+1)'(1);
      pamd_pkg::ST_MCALC: begin
        d2 <= 34'(di * di) + 34'(dq * dq);
        begin
          logic signed [MW-1:0] s;
          s = '0;
          for (int j = 0; j < MAX_BITS; j++) begin
            if (j < 32'(nb)) s = lbit(pidx, nb, j) ? s - MW'(pri[j]) : s + MW'(pri[j]);
          end
          psum <= s;
        end
      end
      pamd_pkg::ST_MMUL: if (idx == npts) begin
        idx <= '0;
        have0 <= 1'b0;
        have1 <= 1'b0;
      end
      pamd_pkg::ST_XRD: idx <= idx + (AW+1)'(1);
      pamd_pkg::ST_XCMP: begin
        if (mb) begin
          if (!have1 || mval > max1) begin max1 <= mval; have1 <= 1'b1; end
        end else begin
          if (!have0 || mval > max0) begin max0 <= mval; have0 <= 1'b1; end
        end
        if (idx != npts) idx <= idx + (AW+1)'(1);
        else begin
          idx <= '0;
        end
      end
      pamd_pkg::ST_OUT: begin
        if (m_axis_tready) begin
          kbit <= kbit + BW'(1);
          have0 <= 1'b0;
          have1 <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Result word, formed from the finished maxima.
  always_comb begin
    if (half > Hi) llr_out = LLR_WIDTH'(Hi);
    else if (half < Lo) llr_out = LLR_WIDTH'(Lo);
    else llr_out = half[LLR_WIDTH-1:0];
    pos_out  = kbit;
    last_out = (32'(kbit) == 32'(nb) - 1);
  end

  assign m_axis_tvalid = (state == pamd_pkg::ST_OUT);
  assign m_axis_tdata  = OW'({pos_out, llr_out});
  assign m_axis_tlast  = last_out;

  // No input word is taken while a result is on offer.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(m_axis_tvalid && s_axis_tready)) else $error("input taken during output");
  // The point counter never runs past the point count.
  a_idx: assert property (@(posedge clk) disable iff (rst)
    idx <= npts) else $error("point counter overrun");
  // A finished symbol always returns to idle.
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
    else $error("no return to idle");

endmodule

// File: tb/prior_aware_maxlog_demapper_tb.sv
module prior_aware_maxlog_demapper_tb;

  localparam int NBITS = 8;
  localparam int DEPTH = 256;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    logic signed [15:0] llr;
    logic [2:0]         pos;
    logic               last;
  } llr_word_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // tdata: point_index, coord_i, coord_q, prior_0..prior_7
  logic [167:0] s_axis_tdata;
  // tuser: req_type
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // tdata: ext_llr, bit_position, zero fill
  logic [23:0]  m_axis_tdata;
  logic         m_axis_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [0:0]   cfg_index;
  logic [15:0]  cfg_data;

  // Shadow copy of the block's table and settings.
  logic signed [15:0] pt_i [DEPTH];
  logic signed [15:0] pt_q [DEPTH];
  bit                 pt_loaded [DEPTH];
  logic [3:0]         bits_reg;
  logic [15:0]        noise_reg;

  llr_word_t llr_queue[$];
  int        errors;
  int        cycles;
  bit        hold_off;
  int        burst_left;

  prior_aware_maxlog_demapper u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bits in use after clamping to the supported range.
  function automatic int active_bits();
    int b;
    b = bits_reg;
    if (b < 2) b = 2;
    if (b > NBITS) b = NBITS;
    return b;
  endfunction

  // Works out the extrinsic LLR of every label bit for one sample.
  function automatic void predict_llrs(input logic signed [15:0] yi,
                                       input logic signed [15:0] yq,
                                       input logic signed [15:0] pri [NBITS]);
    int nb, npts;
    longint metric [DEPTH];
    longint di, dq, m, max0, max1, d;
    longint unsigned prod;
    bit have0, have1, bitv;
    llr_word_t w;
    nb = active_bits();
    npts = 1 << nb;
    for (int p = 0; p < npts; p++) begin
      di = longint'(yi) - longint'(pt_i[p]);
      dq = longint'(yq) - longint'(pt_q[p]);
      prod = longint'(di * di + dq * dq) * longint'(noise_reg);
      m = -longint'((prod + (64'd1 << 24)) >> 25);
      for (int j = 0; j < nb; j++) begin
        bitv = (p >> (nb - 1 - j)) & 1;
        m += bitv ? -longint'(pri[j]) : longint'(pri[j]);
      end
      metric[p] = m;
    end
    for (int k = 0; k < nb; k++) begin
      have0 = 0;
      have1 = 0;
      max0 = 0;
      max1 = 0;
      for (int p = 0; p < npts; p++) begin
        bitv = (p >> (nb - 1 - k)) & 1;
        m = metric[p] - (bitv ? -longint'(pri[k]) : longint'(pri[k]));
        if (bitv) begin
          if (!have1 || m > max1) begin
            max1 = m;
            have1 = 1;
          end
        end else if (!have0 || m > max0) begin
          max0 = m;
          have0 = 1;
        end
      end
      d = max0 - max1 + 1;
      d = (d >= 0) ? d / 2 : -((-d + 1) / 2);
      if (d > 32767) d = 32767;
      if (d < -32768) d = -32768;
      w.llr = d[15:0];
      w.pos = k[2:0];
      w.last = (k == nb - 1);
      llr_queue.insert(llr_queue.size(), w);
    end
  endfunction

  // Sends one word in a sender burst pattern and updates the prediction.
  // Valid stays high after acceptance until the next word or a gap replaces it.
  task automatic send_word(input logic kind, input logic [7:0] idx,
                           input logic signed [15:0] ci, input logic signed [15:0] cq,
                           input logic signed [15:0] pri [NBITS]);
    logic [127:0] pbus;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    for (int j = 0; j < NBITS; j++) pbus[16*j +: 16] = pri[j];
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {pbus, cq, ci, idx};
    do @(posedge clk); while (!s_axis_tready);
    if (kind == pamd_pkg::REQ_LOAD) begin
      pt_i[idx] = ci;
      pt_q[idx] = cq;
      pt_loaded[idx] = 1;
    end else begin
      predict_llrs(ci, cq, pri);
    end
  endtask

  // Register write while the block is idle.
  task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
    s_axis_tvalid <= 1'b0;
    wait (llr_queue.size() == 0);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == pamd_pkg::REG_BITS) bits_reg = val[3:0];
    else noise_reg = val;
  endtask

  task automatic rand_priors(output logic signed [15:0] pri [NBITS], input int mode);
    for (int j = 0; j < NBITS; j++) begin
      case (mode)
        0: pri[j] = 16'sh0000;
        1: pri[j] = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        default: pri[j] = $urandom_range(0, 3) == 0 ? 16'($urandom) :
                          16'($signed($urandom_range(0, 2048)) - 1024);
      endcase
    end
  endtask

  // Loads the first 2^nb points: random coordinates, or corner values at the field extremes.
  task automatic load_points(input int nb, input bit extreme);
    logic signed [15:0] pri [NBITS];
    logic signed [15:0] ci, cq;
    rand_priors(pri, 2);
    for (int p = 0; p < (1 << nb); p++) begin
      if (extreme) begin
        ci = (p & 1) ? 16'sh7fff : 16'sh8000;
        cq = (p & 2) ? 16'sh7fff : 16'sh8000;
      end else begin
        ci = 16'($urandom);
        cq = 16'($urandom);
      end
      send_word(pamd_pkg::REQ_LOAD, p[7:0], ci, cq, pri);
    end
  endtask

  task automatic demap_one(input int mode);
    logic signed [15:0] pri [NBITS];
    rand_priors(pri, mode);
    send_word(pamd_pkg::REQ_DEMAP, 8'($urandom), 16'($urandom), 16'($urandom), pri);
  endtask

  // Field extremes, both request kinds, zero noise scale and a clamped bit count.
  task automatic test_directed();
    logic signed [15:0] pri [NBITS];
    load_points(2, 1);
    write_reg(pamd_pkg::REG_BITS, 16'd0);
    rand_priors(pri, 1);
    send_word(pamd_pkg::REQ_DEMAP, 8'hff, 16'sh7fff, 16'sh8000, pri);
    send_word(pamd_pkg::REQ_DEMAP, 8'h00, 16'sh8000, 16'sh7fff, pri);
    write_reg(pamd_pkg::REG_NOISE, 16'hffff);
    demap_one(0);
    demap_one(1);
    write_reg(pamd_pkg::REG_NOISE, 16'h0000);
    demap_one(1);
    demap_one(2);
    load_points(3, 0);
    write_reg(pamd_pkg::REG_BITS, 16'd3);
    write_reg(pamd_pkg::REG_NOISE, 16'd256);
    demap_one(2);
    demap_one(0);
  endtask

  // Receiver pressure: long hold-off while demap words queue up.
  task automatic test_backpressure();
    hold_off = 1;
    repeat (4) demap_one(2);
    hold_off = 0;
  endtask

  // Random demaps across several configurations, including the widest symbols.
  task automatic test_random();
    int nbs [5] = '{2, 4, 3, 15, 5};
    logic signed [15:0] zp [NBITS];
    rand_priors(zp, 0);
    for (int c = 0; c < 5; c++) begin
      write_reg(pamd_pkg::REG_NOISE, c == 1 ? 16'hffff : 16'($urandom_range(0, 4096)));
      write_reg(pamd_pkg::REG_BITS, 16'(nbs[c]));
      if (active_bits() > 5) begin
        load_points(8, 0);
        repeat (3) demap_one(2);
      end else begin
        // Every point in use must hold a loaded value before a demap.
        if (!pt_loaded[(1 << active_bits()) - 1]) load_points(active_bits(), 0);
        for (int n = 0; n < 10; n++) begin
          if ($urandom_range(0, 9) == 0)
            send_word(pamd_pkg::REQ_LOAD, 8'($urandom_range(0, (1 << active_bits()) - 1)),
                      16'($urandom), 16'($urandom), zp);
          else
            demap_one(2);
        end
      end
    end
    write_reg(pamd_pkg::REG_BITS, 16'd6);
  endtask

  // Receiver stall pattern, with a long hold-off when asked.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (2000) @(posedge clk);
        hold_off = 0;
      end else if (cycles % 3000 < 1000) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    llr_word_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (llr_queue.size() == 0) begin
        $display("%0t: unexpected word %h", $time, m_axis_tdata);
        errors++;
      end else begin
        w = llr_queue.pop_front();
        if (m_axis_tdata[15:0] !== w.llr || m_axis_tdata[18:16] !== w.pos
            || m_axis_tlast !== w.last) begin
          $display("%0t: expected llr %0d bit %0d last %0b, actual llr %0d bit %0d last %0b",
                   $time, w.llr, w.pos, w.last, $signed(m_axis_tdata[15:0]),
                   m_axis_tdata[18:16], m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // Run time limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL prior_aware_maxlog_demapper");
      $finish;
    end
  end

  initial begin
    int waited;
    errors = 0;
    cycles = 0;
    hold_off = 0;
    burst_left = 0;
    bits_reg = 4'd6;
    noise_reg = 16'd256;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    waited = 0;
    while (llr_queue.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (1200) @(posedge clk);
    if (errors == 0 && llr_queue.size() == 0) begin
      $display("PASS prior_aware_maxlog_demapper");
    end else begin
      $display("FAIL prior_aware_maxlog_demapper");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/pamd_pkg.sv
sv/pamd_ram.sv
sv/prior_aware_maxlog_demapper.sv
tb/prior_aware_maxlog_demapper_tb.sv
